>>> hdl/itra_pkg.sv
// ----------------------------------------------------------------------------
// itra_pkg: shared types and constants for integer_to_radix_ascii
// Holds the divider control and status bundles, the character constants and
// the digit glyph lookup used by the sequencer.
// ----------------------------------------------------------------------------
package itra_pkg;

	// Radix limits and fixed digit width (radix <= 16 gives 4-bit digits)
	localparam logic [4:0] RADIX_MIN      = 5'd2;
	localparam logic [4:0] RADIX_MAX      = 5'd16;
	localparam int         DIGIT_W        = 4;
	localparam int         BITS_PER_CYCLE = 4;

	localparam logic [7:0] ASCII_MINUS = 8'h2D;
	localparam logic [7:0] ASCII_NONE  = 8'h00;

	// Sequencer states, one-hot
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_SIGN = 4'b0100,
		ST_EMIT = 4'b1000
	} seq_state_t;

	// Divider control: load a new dividend, or divide the last quotient again
	typedef struct packed {
		logic load;
		logic again;
	} div_ctl_t;

	// Divider status: done pulses for one cycle, digit and q_zero valid then
	typedef struct packed {
		logic               done;
		logic               q_zero;
		logic [DIGIT_W-1:0] digit;
	} div_stat_t;

	// Digit value to upper-case ASCII glyph
	function automatic logic [7:0] digit_glyph(input logic [DIGIT_W-1:0] d);
		logic [7:0] g;
		unique case (d)
			4'd0:  g = 8'h30;
			4'd1:  g = 8'h31;
			4'd2:  g = 8'h32;
			4'd3:  g = 8'h33;
			4'd4:  g = 8'h34;
			4'd5:  g = 8'h35;
			4'd6:  g = 8'h36;
			4'd7:  g = 8'h37;
			4'd8:  g = 8'h38;
			4'd9:  g = 8'h39;
			4'd10: g = 8'h41;
			4'd11: g = 8'h42;
			4'd12: g = 8'h43;
			4'd13: g = 8'h44;
			4'd14: g = 8'h45;
			4'd15: g = 8'h46;
			default: g = 8'h30;
		endcase
		return g;
	endfunction

endpackage

>>> hdl/itra_div.sv
// ----------------------------------------------------------------------------
// itra_div: iterative divider by a small radix
// Restoring division, four quotient bits per cycle. The quotient builds up in
// the dividend register, so a follow-up division of the quotient only needs
// the remainder and the group counter cleared.
// ----------------------------------------------------------------------------
module itra_div #(
	parameter int W = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  itra_pkg::div_ctl_t  ctl,
	input  logic [W-1:0]        dividend,
	input  logic [4:0]          divisor,
	output itra_pkg::div_stat_t stat
);

	localparam int STEP   = itra_pkg::BITS_PER_CYCLE;
	localparam int PAD_W  = ((W + STEP - 1) / STEP) * STEP;
	localparam int GROUPS = PAD_W / STEP;
	localparam int CNT_W  = $clog2(GROUPS + 1);

	logic [PAD_W-1:0]                 acc_q;
	logic [itra_pkg::DIGIT_W-1:0]     rem_q;
	logic [4:0]                       divisor_q;
	logic [CNT_W-1:0]                 cnt_q;
	logic                             run_q;
	logic                             done_q;

	logic [PAD_W-1:0]                 acc_v;
	logic [itra_pkg::DIGIT_W-1:0]     rem_v;
	logic [4:0]                       trial_v;

	// Four restoring steps; remainder stays below the divisor (<= 16)
	always_comb begin
		acc_v   = acc_q;
		rem_v   = rem_q;
		trial_v = '0;
		for (int k = 0; k < STEP; k++) begin
			trial_v = {rem_v, acc_v[PAD_W-1]};
			acc_v   = {acc_v[PAD_W-2:0], 1'b0};
			if (trial_v >= divisor_q) begin
				trial_v  = trial_v - divisor_q;
				acc_v[0] = 1'b1;
			end
			rem_v = trial_v[itra_pkg::DIGIT_W-1:0];
		end
	end

	// Control: run flag, group counter, done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.load || ctl.again) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(GROUPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: dividend/quotient, remainder, divisor
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			acc_q     <= PAD_W'(dividend);
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (ctl.again) begin
			rem_q <= '0;
		end else if (run_q) begin
			acc_q <= acc_v;
			rem_q <= rem_v;
		end
	end

	assign stat.done   = done_q;
	assign stat.q_zero = (acc_q == '0);
	assign stat.digit  = rem_q;

endmodule

>>> hdl/itra_stack.sv
// ----------------------------------------------------------------------------
// itra_stack: digit store
// Digits are written least significant first and read back in reverse.
// One write port, one registered read port.
// ----------------------------------------------------------------------------
module itra_stack #(
	parameter int DEPTH = 32,
	parameter int IDX_W = 5
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [IDX_W-1:0]              waddr,
	input  logic [itra_pkg::DIGIT_W-1:0]  wdata,
	input  logic [IDX_W-1:0]              raddr,
	output logic [itra_pkg::DIGIT_W-1:0]  rdata
);

	logic [itra_pkg::DIGIT_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/integer_to_radix_ascii.sv
// ----------------------------------------------------------------------------
// integer_to_radix_ascii: signed integer to ASCII text in radix 2..16
// Emits '-' for negative values, then the digits of the magnitude, most
// significant first, one character per beat; last marks the final one.
//
//   channel  | handshake         | payload
//   ---------+-------------------+------------------------------------------
//   command  | start / busy      | value[VALUE_WIDTH-1:0] (signed), radix[4:0]
//   result   | strobe            | out_char[7:0], last, bad_radix
//
// A bad radix gives its single beat in the cycle after start, and the block
// stays free. Otherwise each digit takes one pass of the shared divider
// (four quotient bits a cycle) and is pushed on the stack; then come the
// sign slot and the characters. busy is high from the cycle after start
// up to the cycle before the last beat, so a new command can be taken
// during that last beat.
// Reset is asynchronous, active low, and returns the sequencer to idle.
// Result beats last one cycle each; the receiver cannot stall them.
// ----------------------------------------------------------------------------
module integer_to_radix_ascii #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [VALUE_WIDTH-1:0] value,
	input  logic [4:0]                    radix,
	output logic                          strobe,
	output logic [7:0]                    out_char,
	output logic                          last,
	output logic                          bad_radix
);

	localparam int IDX_W = $clog2(VALUE_WIDTH);
	localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

	itra_pkg::seq_state_t state_q, state_d;
	logic [CNT_W-1:0]     cnt_q, cnt_d;
	logic [IDX_W-1:0]     rd_idx_q, rd_idx_d;
	logic [IDX_W-1:0]     rd_addr;
	logic                 neg_q, neg_d;

	itra_pkg::div_ctl_t   div_ctl;
	itra_pkg::div_stat_t  div_stat;
	logic                 push;
	logic [itra_pkg::DIGIT_W-1:0] rd_digit;

	logic [VALUE_WIDTH-1:0] value_u;
	logic [VALUE_WIDTH-1:0] mag;
	logic                   radix_bad;

	logic       o_strobe, o_last, o_bad;
	logic [7:0] o_char;

	// Magnitude of the two's complement input, held unsigned
	assign value_u   = value;
	assign mag       = value_u[VALUE_WIDTH-1] ? (~value_u + 1'b1) : value_u;
	assign radix_bad = (radix < itra_pkg::RADIX_MIN) || (radix > itra_pkg::RADIX_MAX);

	itra_div #(
		.W (VALUE_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (mag),
		.divisor  (radix),
		.stat     (div_stat)
	);

	itra_stack #(
		.DEPTH (VALUE_WIDTH),
		.IDX_W (IDX_W)
	) u_stack (
		.clk   (clk),
		.we    (push),
		.waddr (cnt_q[IDX_W-1:0]),
		.wdata (div_stat.digit),
		.raddr (rd_addr),
		.rdata (rd_digit)
	);

	// Sequencer
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		rd_idx_d = rd_idx_q;
		rd_addr  = rd_idx_q;
		neg_d    = neg_q;
		div_ctl  = '0;
		push     = 1'b0;
		o_strobe = 1'b0;
		o_char   = itra_pkg::ASCII_NONE;
		o_last   = 1'b0;
		o_bad    = 1'b0;
		unique case (state_q)
			itra_pkg::ST_IDLE: begin
				if (start) begin
					if (radix_bad) begin
						o_strobe = 1'b1;
						o_last   = 1'b1;
						o_bad    = 1'b1;
					end else begin
						div_ctl.load = 1'b1;
						cnt_d        = '0;
						neg_d        = value_u[VALUE_WIDTH-1];
						state_d      = itra_pkg::ST_DIV;
					end
				end
			end
			itra_pkg::ST_DIV: begin
				if (div_stat.done) begin
					push  = 1'b1;
					cnt_d = cnt_q + 1'b1;
					if (div_stat.q_zero) begin
						state_d = itra_pkg::ST_SIGN;
					end else begin
						div_ctl.again = 1'b1;
					end
				end
			end
			itra_pkg::ST_SIGN: begin
				// Sign slot; also fetch the most significant digit
				o_strobe = neg_q;
				o_char   = neg_q ? itra_pkg::ASCII_MINUS : itra_pkg::ASCII_NONE;
				rd_addr  = IDX_W'(cnt_q - 1'b1);
				rd_idx_d = IDX_W'(cnt_q - 1'b1);
				state_d  = itra_pkg::ST_EMIT;
			end
			itra_pkg::ST_EMIT: begin
				o_strobe = 1'b1;
				o_char   = itra_pkg::digit_glyph(rd_digit);
				o_last   = (rd_idx_q == '0);
				if (rd_idx_q == '0) begin
					state_d = itra_pkg::ST_IDLE;
				end else begin
					rd_addr  = rd_idx_q - 1'b1;
					rd_idx_d = rd_idx_q - 1'b1;
				end
			end
			default: begin
				state_d = itra_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itra_pkg::ST_IDLE;
			strobe  <= 1'b0;
		end else begin
			state_q <= state_d;
			strobe  <= o_strobe;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		cnt_q     <= cnt_d;
		rd_idx_q  <= rd_idx_d;
		neg_q     <= neg_d;
		out_char  <= o_char;
		last      <= o_last;
		bad_radix <= o_bad;
	end

	assign busy = (state_q != itra_pkg::ST_IDLE);

	// Assertions
	a_bad_beat: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && bad_radix |-> last && (out_char == itra_pkg::ASCII_NONE))
		else $error("bad radix beat malformed");

	a_final_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == itra_pkg::ST_EMIT) && (rd_idx_q == '0) |=> strobe && last && !busy)
		else $error("final digit not marked last");

	a_good_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !radix_bad |=> busy && !strobe)
		else $error("valid command not taken");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == itra_pkg::ST_DIV))
		else $error("divider result outside divide phase");

endmodule
